// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port checker of this block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("port check failed: implication");

// A stalled valid must stay up with its payload unchanged in the next cycle.
`define ASSERT_HOLD(lbl, vld, rdy, data) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && !(rdy)) |=> ((vld) && $stable(data))) \
		else $error("port check failed: stalled item changed");

`endif

// ===== hw/rtl/rptc_pkg.sv =====
// Package for the RGB pair to terminal cell block: cell kinds, lane result
// types and the quantizer helper functions. No dependencies.
package rptc_pkg;

	typedef enum logic [2:0] {
		CELL_BLANK = 3'd0,
		CELL_LOWER = 3'd1,
		CELL_UPPER = 3'd2,
		CELL_SOLID = 3'd3,
		CELL_PAIR  = 3'd4
	} cell_kind_t;

	localparam logic [7:0] CUBE_BASE  = 8'd16;
	localparam logic [7:0] GREY_BLACK = 8'd16;
	localparam logic [7:0] GREY_TOP   = 8'd231;

	// Quantized color of one pixel and whether that pixel is transparent.
	typedef struct packed {
		logic [7:0] index;
		logic       clear;
	} lane_res_t;

	// Both lane results of one item on their way to the merging stage.
	typedef struct packed {
		logic      valid;
		lane_res_t upper;
		lane_res_t lower;
		logic      row_last;
	} pair_s1_t;

	// Rounded divide by 40 with offset 55; below 75 gives level 0.
	function automatic logic [2:0] cube_level(input logic [7:0] x);
		logic [2:0] lvl;
		lvl = 3'd0;
		if (x >= 8'd75)  lvl = 3'd1;
		if (x >= 8'd115) lvl = 3'd2;
		if (x >= 8'd155) lvl = 3'd3;
		if (x >= 8'd195) lvl = 3'd4;
		if (x >= 8'd235) lvl = 3'd5;
		return lvl;
	endfunction

	// Rounded divide by 10 with offset 8; below 14 gives level 0.
	// The divide by 10 is a multiply by 205 and a shift by 11, exact here.
	function automatic logic [4:0] grey_level(input logic [7:0] x);
		logic [15:0] prod;
		prod = 16'(x - 8'd3) * 16'd205;
		return (x < 8'd14) ? 5'd0 : prod[15:11];
	endfunction

	// Grey ramp entry chosen from the red cube level.
	function automatic logic [7:0] grey_index(input logic [2:0] cr);
		logic [7:0] idx;
		unique case (cr)
			3'd0:    idx = GREY_BLACK;
			3'd1:    idx = 8'd236;
			3'd2:    idx = 8'd241;
			3'd3:    idx = 8'd246;
			3'd4:    idx = 8'd251;
			default: idx = GREY_TOP;
		endcase
		return idx;
	endfunction

endpackage

// ===== hw/rtl/rgb_pair_to_terminal_cell.sv =====
// An accepted item goes through the lane result register, then the merge output register.
// Throughput: one item per cycle; two quantizer lanes work on both pixels
// at once, and the only stall comes from out_ready.
// Reset (arst_n low, asynchronous) empties both pipeline stages.
// Depends on rptc_pkg, rptc_quant_lane and rptc_merge.
module rgb_pair_to_terminal_cell import rptc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] top_red,
	input  logic [7:0] top_green,
	input  logic [7:0] top_blue,
	input  logic [7:0] top_alpha,
	input  logic [7:0] low_red,
	input  logic [7:0] low_green,
	input  logic [7:0] low_blue,
	input  logic [7:0] low_alpha,
	input  logic       row_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] cell_kind,
	output logic [7:0] fore_index,
	output logic [7:0] back_index,
	output logic       row_end
);

	lane_res_t top_res, low_res;
	lane_res_t top_res_s1, low_res_s1;
	logic      valid_s1, row_last_s1;
	logic      merge_ready;
	pair_s1_t  pair_s1;

	rptc_quant_lane u_lane_top (
		.red   (top_red),
		.green (top_green),
		.blue  (top_blue),
		.alpha (top_alpha),
		.res   (top_res)
	);

	rptc_quant_lane u_lane_low (
		.red   (low_red),
		.green (low_green),
		.blue  (low_blue),
		.alpha (low_alpha),
		.res   (low_res)
	);

	assign in_ready = !valid_s1 || merge_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			top_res_s1  <= top_res;
			low_res_s1  <= low_res;
			row_last_s1 <= row_last;
		end
	end

	assign pair_s1.valid    = valid_s1;
	assign pair_s1.upper    = top_res_s1;
	assign pair_s1.lower    = low_res_s1;
	assign pair_s1.row_last = row_last_s1;

	rptc_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair       (pair_s1),
		.pair_ready (merge_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_kind  (cell_kind),
		.fore_index (fore_index),
		.back_index (back_index),
		.row_end    (row_end)
	);

endmodule

// ===== hw/rtl/rptc_quant_lane.sv =====
// One quantizer lane: maps an RGBA pixel to a 256-color index and a
// transparency flag. Depends on rptc_pkg.
module rptc_quant_lane import rptc_pkg::*; (
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic [7:0] alpha,
	output lane_res_t  res
);

	logic [2:0]  cr, cg, cb;
	logic [4:0]  lr, lg, lb;
	logic [9:0]  sum;
	logic [11:0] thresh;
	logic        grey_pick;
	logic [7:0]  cube_idx;

	assign cr = cube_level(red);
	assign cg = cube_level(green);
	assign cb = cube_level(blue);
	assign lr = grey_level(red);
	assign lg = grey_level(green);
	assign lb = grey_level(blue);

	assign sum = {2'd0, red} + {2'd0, green} + {2'd0, blue};

	// With a shared grey level l, the grey point wins exactly when
	// 2*(r+g+b) < 3*(grey + cube value) = 150*l + 189. At level zero the
	// two points coincide and the cube color is kept.
	assign thresh = 12'd150 * {7'd0, lr} + 12'd189;
	assign grey_pick = (lr == lg) && (lg == lb) && (lr != 5'd0)
		&& ({1'b0, sum, 1'b0} < thresh);

	assign cube_idx = 8'd36 * {5'd0, cr} + 8'd6 * {5'd0, cg} + {5'd0, cb} + CUBE_BASE;

	assign res.index = grey_pick ? grey_index(cr) : cube_idx;
	assign res.clear = (alpha == 8'd0);

endmodule

// ===== hw/rtl/rptc_merge.sv =====
// Merging stage: combines the two lane results into a cell kind with its
// colors and holds them in the output register. Depends on rptc_pkg.
module rptc_merge import rptc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pair_s1_t   pair,
	output logic       pair_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] cell_kind,
	output logic [7:0] fore_index,
	output logic [7:0] back_index,
	output logic       row_end
);

	cell_kind_t kind;
	logic [7:0] fore, back;
	logic       valid_s2;
	cell_kind_t kind_s2;
	logic [7:0] fore_s2, back_s2;
	logic       row_end_s2;

	always_comb begin
		kind = CELL_PAIR;
		fore = 8'd0;
		back = 8'd0;
		priority if (pair.upper.clear && pair.lower.clear) begin
			kind = CELL_BLANK;
		end else if (pair.upper.clear) begin
			kind = CELL_LOWER;
			fore = pair.lower.index;
		end else if (pair.lower.clear) begin
			kind = CELL_UPPER;
			fore = pair.upper.index;
		end else if (pair.upper.index == pair.lower.index) begin
			kind = CELL_SOLID;
			back = pair.upper.index;
		end else begin
			kind = CELL_PAIR;
			fore = pair.upper.index;
			back = pair.lower.index;
		end
	end

	assign pair_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pair_ready) begin
			valid_s2 <= pair.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pair_ready && pair.valid) begin
			kind_s2    <= kind;
			fore_s2    <= fore;
			back_s2    <= back;
			row_end_s2 <= pair.row_last;
		end
	end

	assign out_valid  = valid_s2;
	assign cell_kind  = kind_s2;
	assign fore_index = fore_s2;
	assign back_index = back_s2;
	assign row_end    = row_end_s2;

endmodule

// ===== hw/rtl/rptc_checker.sv =====
// Port-level checker for rgb_pair_to_terminal_cell and its bind statement.
// Depends on rptc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rptc_checker import rptc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] cell_kind,
	input logic [7:0] fore_index,
	input logic [7:0] back_index,
	input logic       row_end
);

	logic        is_blank, is_half, is_solid, is_pair;
	logic [19:0] out_data;

	assign is_blank = out_valid && (cell_kind == CELL_BLANK);
	assign is_half  = out_valid && (cell_kind == CELL_LOWER || cell_kind == CELL_UPPER);
	assign is_solid = out_valid && (cell_kind == CELL_SOLID);
	assign is_pair  = out_valid && (cell_kind == CELL_PAIR);
	assign out_data = {cell_kind, fore_index, back_index, row_end};

	// A blank cell carries no colors.
	`ASSERT_IMPL(a_blank_no_color, is_blank, fore_index == 8'd0 && back_index == 8'd0)

	// Half-block cells use only the foreground.
	`ASSERT_IMPL(a_half_no_back, is_half, back_index == 8'd0)

	// A solid cell uses only the background.
	`ASSERT_IMPL(a_solid_no_fore, is_solid, fore_index == 8'd0)

	// Two-color cells only arise when the pixels differ.
	`ASSERT_IMPL(a_pair_differs, is_pair, fore_index != back_index)

	`ASSERT_HOLD(a_out_hold, out_valid, out_ready, out_data)

endmodule

bind rgb_pair_to_terminal_cell rptc_checker u_rptc_checker (.*);

// ===== verif/tb_top.sv =====
// Testbench for rgb_pair_to_terminal_cell: drives pixel pairs over valid/ready,
// predicts each terminal cell and checks the results in order of acceptance.
// Depends on rptc_pkg and the RTL of the block.
module tb_top;
	import rptc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int GREY_FLOOR   = 14;
	localparam int GREY_OFFSET  = 8;
	localparam int GREY_STEP    = 10;
	localparam int CUBE_FLOOR   = 75;
	localparam int CUBE_OFFSET  = 55;
	localparam int CUBE_STEP    = 40;
	localparam int RAMP_TOP     = 231;
	localparam int CUBE_STRIDE  = 36;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	typedef struct {
		cell_kind_t kind;
		logic [7:0] fore;
		logic [7:0] back;
		logic       row_end;
	} cell_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] top_red = '0, top_green = '0, top_blue = '0, top_alpha = '0;
	logic [7:0] low_red = '0, low_green = '0, low_blue = '0, low_alpha = '0;
	logic       row_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] cell_kind;
	logic [7:0] fore_index;
	logic [7:0] back_index;
	logic       row_end;

	cell_t pending_cells[$];
	int    error_count = 0;
	int    idle_pct = 0;
	int    stall_pct = 0;
	int    quiet_cycles = 0;

	rgb_pair_to_terminal_cell u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.top_red(top_red), .top_green(top_green), .top_blue(top_blue),
		.top_alpha(top_alpha),
		.low_red(low_red), .low_green(low_green), .low_blue(low_blue),
		.low_alpha(low_alpha),
		.row_last(row_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.cell_kind(cell_kind), .fore_index(fore_index), .back_index(back_index),
		.row_end(row_end)
	);

	always #10 clk = ~clk;

	function automatic int grey_step(int x);
		if (x < GREY_FLOOR)
			return 0;
		return (x - GREY_OFFSET) / GREY_STEP +
			(((x - GREY_OFFSET) % GREY_STEP) > 4 ? 1 : 0);
	endfunction

	function automatic int cube_step(int x);
		if (x < CUBE_FLOOR)
			return 0;
		return (x - CUBE_OFFSET) / CUBE_STEP +
			(((x - CUBE_OFFSET) % CUBE_STEP) > 19 ? 1 : 0);
	endfunction

	// The grey test places the shared grey level on both the cube scale and
	// the grey scale; only a strictly closer grey point wins.
	function automatic logic [7:0] xterm_index(pixel_t p);
		int r, g, b, lvl, cr, cg, cb, cube_pt, grey_pt, dist_cube, dist_grey;
		r = p.red;
		g = p.green;
		b = p.blue;
		cr = cube_step(r);
		cg = cube_step(g);
		cb = cube_step(b);
		lvl = grey_step(r);
		if (lvl == grey_step(g) && lvl == grey_step(b)) begin
			cube_pt = lvl ? lvl * CUBE_STEP + CUBE_OFFSET : 0;
			grey_pt = lvl ? lvl * GREY_STEP + GREY_OFFSET : 0;
			dist_cube = (cube_pt - r) ** 2 + (cube_pt - g) ** 2 + (cube_pt - b) ** 2;
			dist_grey = (grey_pt - r) ** 2 + (grey_pt - g) ** 2 + (grey_pt - b) ** 2;
			if (dist_grey < dist_cube)
				return cr ? 8'(RAMP_TOP + (cr % 5) * 5) : GREY_BLACK;
		end
		return 8'(cr * CUBE_STRIDE + cg * 6 + cb + int'(CUBE_BASE));
	endfunction

	function automatic cell_t predict_cell(pixel_t upper, pixel_t lower, logic last);
		cell_t c;
		logic [7:0] up_idx, low_idx;
		up_idx = xterm_index(upper);
		low_idx = xterm_index(lower);
		c.fore = '0;
		c.back = '0;
		c.row_end = last;
		if (upper.alpha == 0 && lower.alpha == 0) begin
			c.kind = CELL_BLANK;
		end else if (upper.alpha == 0) begin
			c.kind = CELL_LOWER;
			c.fore = low_idx;
		end else if (lower.alpha == 0) begin
			c.kind = CELL_UPPER;
			c.fore = up_idx;
		end else if (up_idx == low_idx) begin
			c.kind = CELL_SOLID;
			c.back = up_idx;
		end else begin
			c.kind = CELL_PAIR;
			c.fore = up_idx;
			c.back = low_idx;
		end
		return c;
	endfunction

	// Accepted items are predicted before results are compared, so even a
	// result in the same cycle finds its expectation.
	always @(posedge clk) begin
		cell_t want;
		if (in_valid && in_ready)
			pending_cells.push_back(predict_cell(
				{top_red, top_green, top_blue, top_alpha},
				{low_red, low_green, low_blue, low_alpha}, row_last));
		if (out_valid && out_ready) begin
			if (pending_cells.size() == 0) begin
				$error("unexpected cell: kind %0d fore %0d back %0d row_end %0b",
					cell_kind, fore_index, back_index, row_end);
				error_count++;
			end else begin
				want = pending_cells.pop_front();
				if (cell_kind !== want.kind) begin
					$error("cell_kind: expected %0d, got %0d", want.kind, cell_kind);
					error_count++;
				end
				if (fore_index !== want.fore) begin
					$error("fore_index: expected %0d, got %0d", want.fore, fore_index);
					error_count++;
				end
				if (back_index !== want.back) begin
					$error("back_index: expected %0d, got %0d", want.back, back_index);
					error_count++;
				end
				if (row_end !== want.row_end) begin
					$error("row_end: expected %0b, got %0b", want.row_end, row_end);
					error_count++;
				end
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_cell(pixel_t upper, pixel_t lower, logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		{top_red, top_green, top_blue, top_alpha} <= upper;
		{low_red, low_green, low_blue, low_alpha} <= lower;
		row_last <= last;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	function automatic pixel_t make_pixel(int r, int g, int b, int a);
		return {8'(r), 8'(g), 8'(b), 8'(a)};
	endfunction

	function automatic logic [7:0] level_edge();
		case ($urandom_range(11))
			0: return 8'd0;
			1: return 8'd13;
			2: return 8'd14;
			3: return 8'd74;
			4: return 8'd75;
			5: return 8'd114;
			6: return 8'd115;
			7: return 8'd194;
			8: return 8'd235;
			9: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		int base, ch;
		case ($urandom_range(2))
			0: begin
				p = $urandom;
			end
			1: begin
				// Near-grey colors reach the grey ramp decision.
				base = $urandom_range(255);
				ch = base + $urandom_range(6) - 3;
				p.red = 8'(ch < 0 ? 0 : (ch > 255 ? 255 : ch));
				ch = base + $urandom_range(6) - 3;
				p.green = 8'(ch < 0 ? 0 : (ch > 255 ? 255 : ch));
				ch = base + $urandom_range(6) - 3;
				p.blue = 8'(ch < 0 ? 0 : (ch > 255 ? 255 : ch));
			end
			default: begin
				p.red = level_edge();
				p.green = level_edge();
				p.blue = level_edge();
			end
		endcase
		p.alpha = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		return p;
	endfunction

	task automatic test_cell_kinds();
		send_cell(make_pixel(255, 255, 255, 0), make_pixel(255, 255, 255, 0), 1'b0);
		send_cell(make_pixel(10, 200, 90, 0), make_pixel(200, 10, 90, 1), 1'b0);
		send_cell(make_pixel(200, 10, 90, 255), make_pixel(10, 200, 90, 255), 1'b1);
		// Odd last row: the lower pixel has no alpha and its color is ignored.
		send_cell(make_pixel(120, 60, 240, 77), make_pixel(255, 255, 255, 0), 1'b1);
		send_cell(make_pixel(255, 255, 255, 1), make_pixel(255, 255, 255, 255), 1'b0);
		send_cell(make_pixel(0, 0, 0, 255), make_pixel(255, 255, 255, 255), 1'b1);
		send_cell(make_pixel(0, 0, 0, 0), make_pixel(0, 0, 0, 128), 1'b0);
	endtask

	task automatic test_quantizer_corners();
		// Grey point strictly closer, from low to top red cube level.
		send_cell(make_pixel(128, 128, 128, 255), make_pixel(250, 250, 250, 255), 1'b0);
		send_cell(make_pixel(88, 88, 88, 9), make_pixel(238, 238, 238, 9), 1'b0);
		send_cell(make_pixel(168, 168, 168, 9), make_pixel(208, 208, 208, 9), 1'b1);
		send_cell(make_pixel(18, 18, 18, 9), make_pixel(48, 48, 48, 9), 1'b0);
		// Equal distances at grey level zero keep the cube color; 14 is at grey level one.
		send_cell(make_pixel(5, 5, 5, 9), make_pixel(0, 0, 0, 9), 1'b0);
		send_cell(make_pixel(13, 13, 13, 9), make_pixel(14, 14, 14, 9), 1'b0);
		// Level thresholds on each channel in turn.
		send_cell(make_pixel(74, 75, 114, 9), make_pixel(115, 154, 155, 9), 1'b0);
		send_cell(make_pixel(194, 195, 234, 9), make_pixel(235, 254, 255, 9), 1'b1);
		send_cell(make_pixel(255, 0, 0, 9), make_pixel(0, 255, 0, 9), 1'b0);
		send_cell(make_pixel(0, 0, 255, 9), make_pixel(255, 255, 0, 9), 1'b0);
		// Near grey but the grey levels differ, so the cube is used; the last pair is one grey, a solid cell.
		send_cell(make_pixel(128, 129, 134, 9), make_pixel(12, 14, 13, 9), 1'b1);
		send_cell(make_pixel(170, 170, 170, 255), make_pixel(170, 170, 170, 200), 1'b0);
	endtask

	task automatic test_random_stream(int count, int sender_idle, int recv_stall);
		pixel_t upper, lower;
		idle_pct = sender_idle;
		stall_pct = recv_stall;
		repeat (count) begin
			upper = random_pixel();
			lower = random_pixel();
			// Some pairs repeat the upper color to reach solid cells.
			if ($urandom_range(3) == 0)
				lower = {upper.red, upper.green, upper.blue, 8'($urandom_range(1, 255))};
			send_cell(upper, lower, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_cell_kinds();
		test_quantizer_corners();
		test_random_stream(250, 0, 0);
		test_random_stream(250, 75, 0);
		test_random_stream(250, 0, 75);
		test_random_stream(250, 18, 18);
		in_valid <= 1'b0;
		stall_pct = 0;
		while (pending_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
